@@ rtl/core/lrn_pkg.sv @@
// Package for the label range normalizer: default sizes, queue depth,
// the codes for how a map item is finished, and the front-to-back control struct.
// No dependencies.
package lrn_pkg;

  localparam int LABEL_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH       = 2;

  // How the back end finishes a map item.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ZERO = 2'd0;  // empty or flat range, or label at or below the low end
  localparam kind_t KIND_ONE  = 2'd1;  // label at or above the high end
  localparam kind_t KIND_DIV  = 2'd2;  // strictly inside the range: divide

  typedef struct packed {
    kind_t kind;
    logic  is_labeled;
  } lrn_ctrl_t;

  localparam int CTRL_BITS = $bits(lrn_ctrl_t);

endpackage

@@ rtl/core/lrn_queue.sv @@
// Small register queue that decouples the normalizer front end from the divider.
// Depends on nothing; width and depth come from parameters.
module lrn_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/core/lrn_front.sv @@
// Front end of the label range normalizer: accepts pixels, tracks the scanned range
// and classifies map pixels into queue entries. Depends on lrn_pkg.
module lrn_front #(
  parameter int LABEL_BITS = lrn_pkg::LABEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pixel_valid,
  output logic                         pixel_stall,
  input  logic                         req_type,
  input  logic                         start_req,
  input  logic signed [LABEL_BITS-1:0] label_value,
  input  logic                         q_full,
  output logic                         q_push,
  output lrn_pkg::lrn_ctrl_t           q_ctrl,
  output logic [LABEL_BITS-1:0]        q_num,
  output logic [LABEL_BITS-1:0]        q_den
);

  localparam logic signed [LABEL_BITS-1:0] LBL_TOP    = {1'b0, {(LABEL_BITS - 1){1'b1}}};
  localparam logic signed [LABEL_BITS-1:0] LBL_BOTTOM = {1'b1, {(LABEL_BITS - 1){1'b0}}};

  logic signed [LABEL_BITS-1:0] range_low;
  logic signed [LABEL_BITS-1:0] range_high;
  logic signed [LABEL_BITS-1:0] base_low;
  logic signed [LABEL_BITS-1:0] base_high;
  logic signed [LABEL_BITS-1:0] range_low_next;
  logic signed [LABEL_BITS-1:0] range_high_next;
  logic signed [LABEL_BITS:0]   num_wide;
  logic signed [LABEL_BITS:0]   den_wide;
  logic                         accept;

  // Map pixels need a queue slot, so the front stalls while the queue is full.
  assign pixel_stall = q_full;
  assign accept      = pixel_valid && !pixel_stall;
  assign q_push      = accept && req_type;

  always_comb begin
    base_low        = start_req ? LBL_TOP : range_low;
    base_high       = start_req ? LBL_BOTTOM : range_high;
    range_low_next  = (label_value < base_low)  ? label_value : base_low;
    range_high_next = (label_value > base_high) ? label_value : base_high;
  end

  // Both differences are non-negative whenever the divider uses them.
  assign num_wide = {label_value[LABEL_BITS-1], label_value} - {range_low[LABEL_BITS-1], range_low};
  assign den_wide = {range_high[LABEL_BITS-1], range_high} - {range_low[LABEL_BITS-1], range_low};
  assign q_num    = num_wide[LABEL_BITS-1:0];
  assign q_den    = den_wide[LABEL_BITS-1:0];

  always_comb begin
    q_ctrl.is_labeled = !label_value[LABEL_BITS-1];
    if (range_high <= range_low) begin
      q_ctrl.kind = lrn_pkg::KIND_ZERO;
    end else if (label_value <= range_low) begin
      q_ctrl.kind = lrn_pkg::KIND_ZERO;
    end else if (label_value >= range_high) begin
      q_ctrl.kind = lrn_pkg::KIND_ONE;
    end else begin
      q_ctrl.kind = lrn_pkg::KIND_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= LBL_TOP;
      range_high <= LBL_BOTTOM;
    end else if (accept && !req_type) begin
      range_low  <= range_low_next;
      range_high <= range_high_next;
    end
  end

endmodule

@@ rtl/core/lrn_back.sv @@
// Back end of the label range normalizer: takes queue entries, runs a restoring
// divider one quotient bit per cycle and holds the result in an output register.
// Depends on lrn_pkg.
module lrn_back #(
  parameter int LABEL_BITS    = lrn_pkg::LABEL_BITS_DEF,
  parameter int FRACTION_BITS = lrn_pkg::FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  lrn_pkg::lrn_ctrl_t       q_ctrl,
  input  logic [LABEL_BITS-1:0]    q_num,
  input  logic [LABEL_BITS-1:0]    q_den,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [FRACTION_BITS:0]   gray_level,
  output logic                     is_labeled
);

  localparam int CNT_W = $clog2(FRACTION_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]               state;
  logic [LABEL_BITS-1:0]    rem;
  logic [LABEL_BITS-1:0]    den;
  logic [FRACTION_BITS-1:0] quot;
  logic [CNT_W-1:0]         cnt;
  lrn_pkg::kind_t           kind;
  logic                     lab;

  logic [LABEL_BITS:0]      shifted;
  logic [LABEL_BITS:0]      diff;
  logic                     fits;
  logic [LABEL_BITS-1:0]    rem_step;
  logic                     out_free;
  logic [FRACTION_BITS:0]   gray_final;

  // The partial remainder stays below the divisor, so one bit of headroom is enough.
  assign shifted  = {rem, 1'b0};
  assign diff     = shifted - {1'b0, den};
  assign fits     = (shifted >= {1'b0, den});
  assign rem_step = fits ? diff[LABEL_BITS-1:0] : shifted[LABEL_BITS-1:0];

  assign out_free = !result_valid || !result_stall;
  assign q_pop    = (state == ST_IDLE) && !q_empty;

  always_comb begin
    case (kind)
      lrn_pkg::KIND_DIV: gray_final = {1'b0, quot};
      lrn_pkg::KIND_ONE: gray_final = {1'b1, {FRACTION_BITS{1'b0}}};
      default:           gray_final = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            state <= (q_ctrl.kind == lrn_pkg::KIND_DIV) ? ST_RUN : ST_DONE;
          end
        end
        ST_RUN: begin
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_pop) begin
          rem  <= q_num;
          den  <= q_den;
          kind <= q_ctrl.kind;
          lab  <= q_ctrl.is_labeled;
          quot <= '0;
          cnt  <= CNT_W'(FRACTION_BITS - 1);
        end
      end
      ST_RUN: begin
        rem  <= rem_step;
        quot <= {quot[FRACTION_BITS-2:0], fits};
        cnt  <= cnt - 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          gray_level <= gray_final;
          is_labeled <= lab;
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule

@@ rtl/core/label_range_normalize.sv @@
// Label range normalizer, top level: front end, queue and divider back end.
// Depends on lrn_pkg, lrn_front, lrn_queue and lrn_back.
//
// Usage: pixels arrive on the pixel channel (pixel_valid / pixel_stall) with
// req_type, start_req and label_value. A scan item (req_type 0) widens the
// running minimum and maximum, and start_req on it first clears the range; a scan
// item gives no result. A map item (req_type 1) gives one result item on the result
// channel (result_valid / result_stall): gray_level, the fraction
// (label - min) / (max - min) with FRACTION_BITS fractional bits, truncated and
// saturated to 0 and 1.0, or 0 when the range is empty or flat, plus is_labeled.
// Scan items are taken one per cycle while the queue has room. A map item that
// falls strictly inside the range runs through the restoring divider, one
// quotient bit per cycle. The back end takes the next map item only once it
// has handed on the last; a saturated or empty-range map item skips the divide
// loop and goes straight to the output register.
// Reset clears the range to empty (min at the largest label, max at the smallest),
// empties the queue and drops any result. While the receiver stalls, the result
// is held, the divider finishes its current item and waits, and the front keeps
// accepting items until the queue of QUEUE_DEPTH entries fills.
module label_range_normalize #(
  parameter int LABEL_BITS    = lrn_pkg::LABEL_BITS_DEF,
  parameter int FRACTION_BITS = lrn_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pixel_valid,
  output logic                         pixel_stall,
  input  logic                         req_type,
  input  logic                         start_req,
  input  logic signed [LABEL_BITS-1:0] label_value,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [FRACTION_BITS:0]       gray_level,
  output logic                         is_labeled
);

  // A queue entry carries the control struct and the numerator and divisor.
  localparam int ENTRY_BITS = lrn_pkg::CTRL_BITS + 2 * LABEL_BITS;

  logic                    q_full;
  logic                    q_empty;
  logic                    q_push;
  logic                    q_pop;
  lrn_pkg::lrn_ctrl_t      push_ctrl;
  logic [LABEL_BITS-1:0]   push_num;
  logic [LABEL_BITS-1:0]   push_den;
  logic [ENTRY_BITS-1:0]   push_entry;
  logic [ENTRY_BITS-1:0]   pop_entry;
  lrn_pkg::lrn_ctrl_t      pop_ctrl;
  logic [LABEL_BITS-1:0]   pop_num;
  logic [LABEL_BITS-1:0]   pop_den;

  lrn_front #(
    .LABEL_BITS (LABEL_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .req_type    (req_type),
    .start_req   (start_req),
    .label_value (label_value),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_ctrl      (push_ctrl),
    .q_num       (push_num),
    .q_den       (push_den)
  );

  assign push_entry = {push_ctrl, push_num, push_den};

  lrn_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (lrn_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_entry),
    .empty     (q_empty)
  );

  assign pop_ctrl = pop_entry[ENTRY_BITS-1 -: lrn_pkg::CTRL_BITS];
  assign pop_num  = pop_entry[2*LABEL_BITS-1 -: LABEL_BITS];
  assign pop_den  = pop_entry[LABEL_BITS-1:0];

  lrn_back #(
    .LABEL_BITS    (LABEL_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_ctrl       (pop_ctrl),
    .q_num        (pop_num),
    .q_den        (pop_den),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .gray_level   (gray_level),
    .is_labeled   (is_labeled)
  );

  // The queue is never written while full.
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue written while full");

  // The back end never takes an entry from an empty queue.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue read while empty");

  // A result never exceeds 1.0.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!gray_level[FRACTION_BITS] || (gray_level[FRACTION_BITS-1:0] == '0)))
    else $error("normalized value above one");

endmodule
